// ----- hdl/greedy_face_run_merger_macros.svh -----
// Assertion macros shared by the greedy face run merger modules.
`ifndef GREEDY_FACE_RUN_MERGER_MACROS_SVH
`define GREEDY_FACE_RUN_MERGER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define GRFM_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("grfm assertion failed");

// Implication checked in the same cycle, outside reset.
`define GRFM_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grfm assertion failed");

// Implication checked in the cycle after, also across reset.
`define GRFM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("grfm assertion failed");

`endif

// ----- hdl/grfm_pkg.sv -----
// Types and constants of the greedy face run merger.
`default_nettype none

package grfm_pkg;

   // Longest run that may ever merge, whatever the register holds.
   localparam int MaxRun = 16;

   // Number of close jobs the face queue holds.
   localparam int QueueDepth = 4;

   // Corner levels of a face with no occlusion at all.
   localparam logic [7:0] AoOpen = 8'hFF;

   // Configuration register indexes.
   localparam logic CsrLightTolerance = 1'b0;
   localparam logic CsrMaxRunLength   = 1'b1;

   // Configuration reset values.
   localparam logic [3:0] LightToleranceReset = 4'd2;
   localparam logic [4:0] MaxRunLengthReset   = 5'd16;

   // One input word: a single cell of the column.
   typedef struct packed {
      logic        visible;
      logic [15:0] cell_block;
      logic [3:0]  light_r;
      logic [3:0]  light_g;
      logic [3:0]  light_b;
      logic [1:0]  rotation;
      logic [7:0]  ao_corners;
      logic        column_end;
   } req_type;

   // One result word: a single emitted face.
   typedef struct packed {
      logic [4:0]  face_start;
      logic [4:0]  face_length;
      logic        merged;
      logic [15:0] face_block;
      logic [3:0]  face_light_r;
      logic [3:0]  face_light_g;
      logic [3:0]  face_light_b;
      logic [1:0]  face_rotation;
      logic [7:0]  face_ao;
      logic        last_of_item;
   } rsp_type;

   // A closed run waiting to be turned into faces.
   typedef struct packed {
      logic [4:0]  start;
      logic [4:0]  length;
      logic        merged;
      logic [15:0] block;
      logic [3:0]  light_r;
      logic [3:0]  light_g;
      logic [3:0]  light_b;
      logic [1:0]  rotation;
      logic [7:0]  ao;
      logic        last;
   } job_type;

   // Up to two closed runs produced by one accepted cell.
   typedef struct packed {
      logic    a_valid;
      logic    b_valid;
      job_type a;
      job_type b;
   } push_type;

   // Configuration register contents.
   typedef struct packed {
      logic [3:0] light_tolerance;
      logic [4:0] max_run_length;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hdl/greedy_face_run_merger.sv -----
// Path: with the queue empty, an accepted cell's closed run enters the run queue, then
// its first face is registered on rsp; faces of runs queued ahead of it come out first.
// Throughput: one cell per cycle while req_ready is high, and one face per cycle while
// rsp_ready is high; a run that splits into single-cell faces holds the output for
// each cell, and req_ready drops once the four-entry run queue has under two free slots.
// Reset (synchronous): no open run, position 0, queue empty, registers at defaults.
`default_nettype none

module greedy_face_run_merger #(
   parameter int COLUMN_LENGTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire grfm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output grfm_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [4:0]        csr_data
);

   grfm_pkg::cfg_type  cfg_ff, cfg_in;
   grfm_pkg::push_type push;
   logic               space_ok;
   logic               accept;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            grfm_pkg::CsrLightTolerance: cfg_in.light_tolerance = csr_data[3:0];
            grfm_pkg::CsrMaxRunLength:   cfg_in.max_run_length  = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_tolerance <= grfm_pkg::LightToleranceReset;
         cfg_ff.max_run_length  <= grfm_pkg::MaxRunLengthReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input word handshake.
   assign req_ready = space_ok;
   assign accept    = req_valid && req_ready;

   grfm_run_tracker #(
      .COLUMN_LENGTH(COLUMN_LENGTH)
   ) u_tracker (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (accept),
      .req_data (req_data),
      .push     (push)
   );

   grfm_face_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hdl/grfm_run_tracker.sv -----
// Run state of the column and the close jobs produced by each cell.
`default_nettype none

module grfm_run_tracker #(
   parameter int COLUMN_LENGTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire grfm_pkg::cfg_type cfg,
   input  wire logic              accept,
   input  wire grfm_pkg::req_type req_data,
   output grfm_pkg::push_type     push
);

   localparam int PosWidth  = $clog2(COLUMN_LENGTH);
   localparam int SpanWidth = (PosWidth + 1 > 6) ? PosWidth + 1 : 6;

   logic                run_active_ff, run_active_in;
   logic [PosWidth-1:0] run_begin_ff, run_begin_in;
   logic [PosWidth-1:0] cell_position_ff, cell_position_in;
   logic [15:0]         run_block_ff, run_block_in;
   logic [3:0]          run_light_r_ff, run_light_r_in;
   logic [3:0]          run_light_g_ff, run_light_g_in;
   logic [3:0]          run_light_b_ff, run_light_b_in;
   logic [1:0]          run_rotation_ff, run_rotation_in;
   logic [7:0]          run_ao_ff, run_ao_in;

   logic [5:0]           limit;
   logic [SpanWidth-1:0] pos_ext;
   logic [SpanWidth-1:0] begin_ext;
   logic [SpanWidth-1:0] begin_next_ext;
   logic [SpanWidth-1:0] span_a;
   logic [SpanWidth-1:0] span_b;
   logic                 light_ok;
   logic                 extend;
   logic                 start_new;
   logic                 close_a;
   logic                 close_b;

   function automatic logic within_tol(input logic [3:0] a, input logic [3:0] b,
                                       input logic [3:0] tol);
      logic [3:0] diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff <= tol;
   endfunction

   // Clamp the run limit into one to the fixed maximum.
   always_comb begin
      if (cfg.max_run_length == 5'd0) begin
         limit = 6'd1;
      end else if ({1'b0, cfg.max_run_length} > 6'(grfm_pkg::MaxRun)) begin
         limit = 6'(grfm_pkg::MaxRun);
      end else begin
         limit = {1'b0, cfg.max_run_length};
      end
   end

   // Decide whether the cell extends the open run.
   assign pos_ext   = SpanWidth'(cell_position_ff);
   assign begin_ext = SpanWidth'(run_begin_ff);
   assign span_a    = pos_ext - begin_ext;
   assign light_ok  = within_tol(req_data.light_r, run_light_r_ff, cfg.light_tolerance)
                   && within_tol(req_data.light_g, run_light_g_ff, cfg.light_tolerance)
                   && within_tol(req_data.light_b, run_light_b_ff, cfg.light_tolerance);
   assign extend    = run_active_ff
                   && (req_data.cell_block == run_block_ff)
                   && (req_data.rotation == run_rotation_ff)
                   && (req_data.ao_corners == run_ao_ff)
                   && (span_a < SpanWidth'(limit))
                   && light_ok;
   assign start_new = req_data.visible && !extend;

   // The open run closes at this cell when it is hidden or does not fit.
   assign close_a = run_active_ff && (!req_data.visible || !extend) && (pos_ext > begin_ext);
   // The column end flushes whatever run is open after this cell.
   assign close_b = req_data.visible && req_data.column_end;

   // Next run state.
   always_comb begin
      run_active_in   = run_active_ff;
      run_begin_in    = run_begin_ff;
      cell_position_in = cell_position_ff;
      run_block_in    = run_block_ff;
      run_light_r_in  = run_light_r_ff;
      run_light_g_in  = run_light_g_ff;
      run_light_b_in  = run_light_b_ff;
      run_rotation_in = run_rotation_ff;
      run_ao_in       = run_ao_ff;
      if (!req_data.visible) begin
         run_active_in = 1'b0;
      end else if (start_new) begin
         run_active_in   = 1'b1;
         run_begin_in    = cell_position_ff;
         run_block_in    = req_data.cell_block;
         run_light_r_in  = req_data.light_r;
         run_light_g_in  = req_data.light_g;
         run_light_b_in  = req_data.light_b;
         run_rotation_in = req_data.rotation;
         run_ao_in       = req_data.ao_corners;
      end
      if (req_data.column_end) begin
         run_active_in    = 1'b0;
         cell_position_in = '0;
      end else if (cell_position_ff != PosWidth'(COLUMN_LENGTH - 1)) begin
         cell_position_in = cell_position_ff + PosWidth'(1);
      end
   end

   assign begin_next_ext = SpanWidth'(run_begin_in);
   assign span_b         = pos_ext + SpanWidth'(1) - begin_next_ext;

   // Close jobs for the old run and for the flushed run.
   always_comb begin
      push.a_valid   = accept && close_a;
      push.a.start   = begin_ext[4:0];
      push.a.length  = span_a[4:0];
      push.a.merged  = (span_a > SpanWidth'(1)) && (run_ao_ff == grfm_pkg::AoOpen);
      push.a.block   = run_block_ff;
      push.a.light_r = run_light_r_ff;
      push.a.light_g = run_light_g_ff;
      push.a.light_b = run_light_b_ff;
      push.a.rotation = run_rotation_ff;
      push.a.ao      = run_ao_ff;
      push.a.last    = !close_b;

      push.b_valid   = accept && close_b;
      push.b.start   = begin_next_ext[4:0];
      push.b.length  = span_b[4:0];
      push.b.merged  = (span_b > SpanWidth'(1)) && (run_ao_in == grfm_pkg::AoOpen);
      push.b.block   = run_block_in;
      push.b.light_r = run_light_r_in;
      push.b.light_g = run_light_g_in;
      push.b.light_b = run_light_b_in;
      push.b.rotation = run_rotation_in;
      push.b.ao      = run_ao_in;
      push.b.last    = 1'b1;
   end

   // Control state takes reset; run attributes are only read while a run is open.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff    <= 1'b0;
         cell_position_ff <= '0;
      end else if (accept) begin
         run_active_ff    <= run_active_in;
         cell_position_ff <= cell_position_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         run_begin_ff    <= run_begin_in;
         run_block_ff    <= run_block_in;
         run_light_r_ff  <= run_light_r_in;
         run_light_g_ff  <= run_light_g_in;
         run_light_b_ff  <= run_light_b_in;
         run_rotation_ff <= run_rotation_in;
         run_ao_ff       <= run_ao_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/grfm_face_queue.sv -----
// Queue of closed runs and the expander that emits one face per cycle unless the output is stalled.
`default_nettype none

`include "greedy_face_run_merger_macros.svh"

module grfm_face_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire grfm_pkg::push_type push,
   output logic                    space_ok,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output grfm_pkg::rsp_type       rsp_data
);

   localparam int PtrWidth   = $clog2(grfm_pkg::QueueDepth);
   localparam int CountWidth = $clog2(grfm_pkg::QueueDepth + 1);

   grfm_pkg::job_type     job_ff [grfm_pkg::QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [4:0]            offset_ff, offset_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   grfm_pkg::rsp_type     rsp_ff, rsp_in;

   grfm_pkg::job_type     head;
   logic [PtrWidth-1:0]   wr_ptr_b;
   logic                  load;
   logic                  final_face;
   logic                  pop;
   logic [1:0]            push_count;

   // Two free slots are needed, since one cell may close two runs.
   assign space_ok = count_ff <= CountWidth'(grfm_pkg::QueueDepth - 2);

   assign head       = job_ff[rd_ptr_ff];
   assign load       = (!rsp_valid_ff || rsp_ready) && (count_ff != '0);
   assign final_face = head.merged || (offset_ff == head.length - 5'd1);
   assign pop        = load && final_face;
   assign push_count = {1'b0, push.a_valid} + {1'b0, push.b_valid};
   assign wr_ptr_b   = push.a_valid ? (wr_ptr_ff + PtrWidth'(1)) : wr_ptr_ff;

   // Pointer, count and output word updates.
   always_comb begin
      wr_ptr_in    = wr_ptr_ff + PtrWidth'(push_count);
      rd_ptr_in    = pop ? (rd_ptr_ff + PtrWidth'(1)) : rd_ptr_ff;
      count_in     = count_ff + CountWidth'(push_count) - CountWidth'(pop);
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.face_start    = head.start + offset_ff;
         rsp_in.face_length   = head.merged ? head.length : 5'd1;
         rsp_in.merged        = head.merged;
         rsp_in.face_block    = head.block;
         rsp_in.face_light_r  = head.light_r;
         rsp_in.face_light_g  = head.light_g;
         rsp_in.face_light_b  = head.light_b;
         rsp_in.face_rotation = head.rotation;
         rsp_in.face_ao       = head.ao;
         rsp_in.last_of_item  = head.last && final_face;
         offset_in            = final_face ? 5'd0 : (offset_ff + 5'd1);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Job storage and the output word carry no reset.
   always_ff @(posedge clock) begin
      if (push.a_valid) begin
         job_ff[wr_ptr_ff] <= push.a;
      end
      if (push.b_valid) begin
         job_ff[wr_ptr_b] <= push.b;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks on queue occupancy and on the emitted faces.
   `GRFM_ASSERT(a_count_bound, count_ff <= CountWidth'(grfm_pkg::QueueDepth))
   `GRFM_ASSERT_IMPLY(a_push_space, push.a_valid || push.b_valid, space_ok)
   `GRFM_ASSERT_IMPLY(a_single_len, rsp_valid_ff && !rsp_ff.merged, rsp_ff.face_length == 5'd1)
   `GRFM_ASSERT_IMPLY(a_merged_len, rsp_valid_ff && rsp_ff.merged, rsp_ff.face_length > 5'd1)
   `GRFM_ASSERT_NEXT(a_reset_idle, reset, !rsp_valid_ff && (count_ff == '0))

endmodule

`default_nettype wire
